/* hw/rtl/rcws_pkg.sv */
// Shared types, constants and angle helpers for the ray cast wall scanner.
package rcws_pkg;

    // Item command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SCAN = 1'b1;

    // Datapath widths
    localparam int DIR_W     = 16;
    localparam int DIFF_W    = 33;
    localparam int MUL_W     = 34;
    localparam int PROD_W    = 68;
    localparam int DEN_W     = 50;
    localparam int CROSS_W   = 67;
    localparam int MAG_W     = 66;
    localparam int NUM_W     = 80;
    localparam int QUO_W     = 34;
    localparam int AXIS_W    = 33;
    localparam int SUM_W     = 65;
    localparam int ROOT_W    = 64;
    localparam int DIST_W    = 32;
    localparam int FRAC_SH   = 14;
    localparam int IDX_W     = 11;
    localparam int DIV_STEPS = 80;
    localparam int ROOT_STEPS = 32;

    localparam logic [ROOT_W-1:0] ROOT_BIT_INIT = 64'h4000_0000_0000_0000;
    localparam logic [9:0] DEG_FULL    = 10'd360;
    localparam logic [9:0] DEG_QUARTER = 10'd90;

    // Quarter-wave sine, Q2.14, one entry per degree
    localparam logic [14:0] SIN_Q14 [0:90] = '{
        15'd0,     15'd286,   15'd572,   15'd857,   15'd1143,
        15'd1428,  15'd1713,  15'd1997,  15'd2280,  15'd2563,
        15'd2845,  15'd3126,  15'd3406,  15'd3686,  15'd3964,
        15'd4240,  15'd4516,  15'd4790,  15'd5063,  15'd5334,
        15'd5604,  15'd5872,  15'd6138,  15'd6402,  15'd6664,
        15'd6924,  15'd7182,  15'd7438,  15'd7692,  15'd7943,
        15'd8192,  15'd8438,  15'd8682,  15'd8923,  15'd9162,
        15'd9397,  15'd9630,  15'd9860,  15'd10087, 15'd10311,
        15'd10531, 15'd10749, 15'd10963, 15'd11174, 15'd11381,
        15'd11585, 15'd11786, 15'd11982, 15'd12176, 15'd12365,
        15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
        15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044,
        15'd14189, 15'd14330, 15'd14466, 15'd14598, 15'd14726,
        15'd14849, 15'd14968, 15'd15082, 15'd15191, 15'd15296,
        15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749,
        15'd15826, 15'd15897, 15'd15964, 15'd16026, 15'd16083,
        15'd16135, 15'd16182, 15'd16225, 15'd16262, 15'd16294,
        15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
        15'd16384
    };

    // Ray offsets in degrees, in ray order
    localparam logic [8:0] RAY_OFFSET [0:7] = '{
        9'd3, 9'd357, 9'd177, 9'd183, 9'd87, 9'd93, 9'd273, 9'd267
    };

    typedef enum logic [3:0] {
        ST_IDLE, ST_RAY, ST_READ, ST_DIFF, ST_MUL, ST_CHECK, ST_DIV, ST_RANGE,
        ST_SCALE, ST_SQUARE, ST_ROOT_INIT, ST_ROOT, ST_UPDATE, ST_EMIT
    } state_t;

    typedef enum logic [3:0] {
        MUL_DX_EY, MUL_DY_EX, MUL_WX_DY, MUL_WY_DX, MUL_WX_EY, MUL_WY_EX,
        MUL_T_DX, MUL_T_DY, MUL_AX_AX, MUL_AY_AY
    } mul_sel_t;

    typedef enum logic [3:0] {
        ACC_NONE, ACC_DEN_LOAD, ACC_DEN_SUB, ACC_S_LOAD, ACC_S_SUB, ACC_N_LOAD,
        ACC_N_SUB, ACC_AX_LOAD, ACC_AY_LOAD, ACC_SUM_LOAD, ACC_SUM_ADD
    } acc_op_t;

    typedef struct packed {
        logic             load_we;
        logic             scan_start;
        logic             ray_init;
        logic [2:0]       ray_idx;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             diff_en;
        logic             mul_en;
        mul_sel_t         mul_sel;
        acc_op_t          acc_op;
        logic             div_init;
        logic             div_step;
        logic             dist_max;
        logic             sqrt_init;
        logic             sqrt_step;
        logic             upd;
    } cmd_t;

    typedef struct packed {
        logic wall_ok;
        logic t_sat;
        logic ax_fit;
        logic sum_ovf;
    } stat_t;

    // Sine of a whole-degree angle below 360, signed Q2.14
    function automatic logic signed [DIR_W-1:0] sin_deg(input logic [8:0] a);
        logic [8:0]  idx;
        logic        neg;
        logic [15:0] mag;
        if (a <= 9'd90) begin
            idx = a;
            neg = 1'b0;
        end else if (a <= 9'd180) begin
            idx = 9'd180 - a;
            neg = 1'b0;
        end else if (a <= 9'd270) begin
            idx = a - 9'd180;
            neg = 1'b1;
        end else begin
            idx = 9'd360 - a;
            neg = 1'b1;
        end
        mag = {1'b0, SIN_Q14[idx[6:0]]};
        return neg ? -mag : mag;
    endfunction

endpackage

/* hw/rtl/rcws_if.sv */
// Input and output channel interfaces of the ray cast wall scanner.
interface rcws_in_if;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [5:0]         wall_index;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic [8:0]         heading;

    modport source (
        output valid, cmd, wall_index, start_x, start_y, end_x, end_y,
               origin_x, origin_y, heading,
        input  ready
    );
    modport sink (
        input  valid, cmd, wall_index, start_x, start_y, end_x, end_y,
               origin_x, origin_y, heading,
        output ready
    );
endinterface

interface rcws_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] distance;
    logic [2:0]  ray_number;
    logic        no_hit;
    logic        last;

    modport source (
        output valid, distance, ray_number, no_hit, last,
        input  ready
    );
    modport sink (
        input  valid, distance, ray_number, no_hit, last,
        output ready
    );
endinterface

/* hw/rtl/rcws_dpath.sv */
// Datapath: wall table, shared multiplier, divider and square root units.
module rcws_dpath #(
    parameter int MAX_WALLS = 64
) (
    input  logic                clk,
    input  rcws_pkg::cmd_t      cmd,
    output rcws_pkg::stat_t     stat,
    input  logic [5:0]          wall_index,
    input  logic signed [31:0]  start_x,
    input  logic signed [31:0]  start_y,
    input  logic signed [31:0]  end_x,
    input  logic signed [31:0]  end_y,
    input  logic signed [31:0]  origin_x,
    input  logic signed [31:0]  origin_y,
    input  logic [8:0]          heading,
    output logic [31:0]         distance,
    output logic                no_hit
);

    localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;

    // Wall table: x in upper half, y in lower half
    logic [63:0] start_mem [0:MAX_WALLS-1];
    logic [63:0] end_mem   [0:MAX_WALLS-1];
    logic [63:0] rd_start_reg;
    logic [63:0] rd_end_reg;

    logic [rcws_pkg::IDX_W-1:0] wr_idx;

    logic [31:0] ox_reg;
    logic [31:0] oy_reg;
    logic [8:0]  head_reg;

    logic signed [rcws_pkg::DIR_W-1:0]  dx_reg;
    logic signed [rcws_pkg::DIR_W-1:0]  dy_reg;
    logic signed [rcws_pkg::DIFF_W-1:0] ex_reg;
    logic signed [rcws_pkg::DIFF_W-1:0] ey_reg;
    logic signed [rcws_pkg::DIFF_W-1:0] wx_reg;
    logic signed [rcws_pkg::DIFF_W-1:0] wy_reg;

    logic signed [rcws_pkg::MUL_W-1:0]  mul_a;
    logic signed [rcws_pkg::MUL_W-1:0]  mul_b;
    logic signed [rcws_pkg::PROD_W-1:0] prod_reg;

    logic signed [rcws_pkg::DEN_W-1:0]   den_reg;
    logic signed [rcws_pkg::DEN_W-1:0]   s_reg;
    logic signed [rcws_pkg::CROSS_W-1:0] n_reg;
    logic [rcws_pkg::AXIS_W-1:0]         ax_reg;
    logic [rcws_pkg::AXIS_W-1:0]         ay_reg;
    logic [rcws_pkg::SUM_W-1:0]          sum_reg;

    logic [rcws_pkg::NUM_W-1:0]   num_reg;
    logic [rcws_pkg::DEN_W-1:0]   dmag_reg;
    logic [rcws_pkg::DEN_W-1:0]   rem_reg;
    logic [rcws_pkg::QUO_W-1:0]   q_reg;
    logic                         sat_reg;

    logic [rcws_pkg::ROOT_W-1:0] sq_v_reg;
    logic [rcws_pkg::ROOT_W-1:0] sq_root_reg;
    logic [rcws_pkg::ROOT_W-1:0] sq_bit_reg;

    logic [rcws_pkg::DIST_W-1:0] best_reg;
    logic                        hit_reg;

    logic [9:0]  sin_arg;
    logic [9:0]  cos_arg;
    logic [8:0]  theta;
    logic [8:0]  theta_cos;
    logic [15:0] dx_mag;
    logic [15:0] dy_mag;

    logic                           den_neg;
    logic                           s_neg;
    logic                           box_ok;
    logic                           behind_ok;
    logic [rcws_pkg::DEN_W-1:0]     den_mag;
    logic [rcws_pkg::CROSS_W-1:0]   n_abs;

    logic [rcws_pkg::DEN_W:0]    rem_sh;
    logic                        q_bit;
    logic [rcws_pkg::DEN_W:0]    rem_new;
    logic [rcws_pkg::ROOT_W-1:0] sq_trial;

    // Write a wall beat into the table, ignore slots past the end
    assign wr_idx = rcws_pkg::IDX_W'(wall_index);

    always_ff @(posedge clk)
    begin
        if (cmd.load_we && (wr_idx < rcws_pkg::IDX_W'(MAX_WALLS)))
        begin
            start_mem[wr_idx[AW-1:0]] <= {start_x, start_y};
            end_mem[wr_idx[AW-1:0]]   <= {end_x, end_y};
        end
        if (cmd.rd_en)
        begin
            rd_start_reg <= start_mem[cmd.rd_addr[AW-1:0]];
            rd_end_reg   <= end_mem[cmd.rd_addr[AW-1:0]];
        end
    end

    // Ray angle and its direction vector
    always_comb
    begin
        sin_arg = 10'(head_reg) + rcws_pkg::DEG_FULL
                - 10'(rcws_pkg::RAY_OFFSET[cmd.ray_idx]);
        if (sin_arg >= rcws_pkg::DEG_FULL)
        begin
            sin_arg = sin_arg - rcws_pkg::DEG_FULL;
        end
        theta   = sin_arg[8:0];
        cos_arg = 10'(theta) + rcws_pkg::DEG_QUARTER;
        if (cos_arg >= rcws_pkg::DEG_FULL)
        begin
            cos_arg = cos_arg - rcws_pkg::DEG_FULL;
        end
        theta_cos = cos_arg[8:0];
    end

    assign dx_mag = dx_reg[15] ? 16'(-dx_reg) : 16'(dx_reg);
    assign dy_mag = dy_reg[15] ? 16'(-dy_reg) : 16'(dy_reg);

    // Hold scan origin and ray set-up
    always_ff @(posedge clk)
    begin
        if (cmd.scan_start)
        begin
            ox_reg   <= origin_x;
            oy_reg   <= origin_y;
            head_reg <= (heading >= 9'd360) ? heading - 9'd360 : heading;
        end
        if (cmd.ray_init)
        begin
            dx_reg   <= rcws_pkg::sin_deg(theta);
            dy_reg   <= rcws_pkg::sin_deg(theta_cos);
            best_reg <= '1;
            hit_reg  <= 1'b0;
        end
        if (cmd.diff_en)
        begin
            ex_reg <= {rd_end_reg[63], rd_end_reg[63:32]}
                    - {rd_start_reg[63], rd_start_reg[63:32]};
            ey_reg <= {rd_end_reg[31], rd_end_reg[31:0]}
                    - {rd_start_reg[31], rd_start_reg[31:0]};
            wx_reg <= {rd_start_reg[63], rd_start_reg[63:32]} - {ox_reg[31], ox_reg};
            wy_reg <= {rd_start_reg[31], rd_start_reg[31:0]} - {oy_reg[31], oy_reg};
        end
        if (cmd.upd)
        begin
            hit_reg <= 1'b1;
            if (sq_root_reg[31:0] < best_reg)
            begin
                best_reg <= sq_root_reg[31:0];
            end
        end
    end

    // Select multiplier operands
    always_comb
    begin
        case (cmd.mul_sel)
            rcws_pkg::MUL_DX_EY:
            begin
                mul_a = {{18{dx_reg[15]}}, dx_reg};
                mul_b = {ey_reg[32], ey_reg};
            end
            rcws_pkg::MUL_DY_EX:
            begin
                mul_a = {{18{dy_reg[15]}}, dy_reg};
                mul_b = {ex_reg[32], ex_reg};
            end
            rcws_pkg::MUL_WX_DY:
            begin
                mul_a = {wx_reg[32], wx_reg};
                mul_b = {{18{dy_reg[15]}}, dy_reg};
            end
            rcws_pkg::MUL_WY_DX:
            begin
                mul_a = {wy_reg[32], wy_reg};
                mul_b = {{18{dx_reg[15]}}, dx_reg};
            end
            rcws_pkg::MUL_WX_EY:
            begin
                mul_a = {wx_reg[32], wx_reg};
                mul_b = {ey_reg[32], ey_reg};
            end
            rcws_pkg::MUL_WY_EX:
            begin
                mul_a = {wy_reg[32], wy_reg};
                mul_b = {ex_reg[32], ex_reg};
            end
            rcws_pkg::MUL_T_DX:
            begin
                mul_a = {1'b0, q_reg[32:0]};
                mul_b = {18'b0, dx_mag};
            end
            rcws_pkg::MUL_T_DY:
            begin
                mul_a = {1'b0, q_reg[32:0]};
                mul_b = {18'b0, dy_mag};
            end
            rcws_pkg::MUL_AX_AX:
            begin
                mul_a = {2'b0, ax_reg[31:0]};
                mul_b = {2'b0, ax_reg[31:0]};
            end
            rcws_pkg::MUL_AY_AY:
            begin
                mul_a = {2'b0, ay_reg[31:0]};
                mul_b = {2'b0, ay_reg[31:0]};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Multiply, then fold the product into its accumulator
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        case (cmd.acc_op)
            rcws_pkg::ACC_DEN_LOAD: den_reg <= prod_reg[49:0];
            rcws_pkg::ACC_DEN_SUB:  den_reg <= den_reg - prod_reg[49:0];
            rcws_pkg::ACC_S_LOAD:   s_reg   <= prod_reg[49:0];
            rcws_pkg::ACC_S_SUB:    s_reg   <= s_reg - prod_reg[49:0];
            rcws_pkg::ACC_N_LOAD:   n_reg   <= prod_reg[66:0];
            rcws_pkg::ACC_N_SUB:    n_reg   <= n_reg - prod_reg[66:0];
            rcws_pkg::ACC_AX_LOAD:  ax_reg  <= prod_reg[46:14];
            rcws_pkg::ACC_AY_LOAD:  ay_reg  <= prod_reg[46:14];
            rcws_pkg::ACC_SUM_LOAD: sum_reg <= {1'b0, prod_reg[63:0]};
            rcws_pkg::ACC_SUM_ADD:  sum_reg <= sum_reg + {1'b0, prod_reg[63:0]};
            default:
            begin
            end
        endcase
    end

    // Wall acceptance: not parallel, inside the box, not behind
    assign den_neg   = den_reg[rcws_pkg::DEN_W-1];
    assign s_neg     = s_reg[rcws_pkg::DEN_W-1];
    assign box_ok    = den_neg ? ((s_neg || (s_reg == '0)) && !(s_reg < den_reg))
                               : (!s_neg && !(s_reg > den_reg));
    assign behind_ok = (n_reg == '0) || (n_reg[rcws_pkg::CROSS_W-1] == den_neg);
    assign den_mag   = den_neg ? 50'(-den_reg) : 50'(den_reg);
    assign n_abs     = n_reg[rcws_pkg::CROSS_W-1] ? 67'(-n_reg) : 67'(n_reg);

    assign stat.wall_ok = (den_reg != '0) && box_ok && behind_ok;
    assign stat.t_sat   = sat_reg | q_reg[rcws_pkg::QUO_W-1];
    assign stat.ax_fit  = !ax_reg[32] && !ay_reg[32];
    assign stat.sum_ovf = sum_reg[rcws_pkg::SUM_W-1];

    // Restoring divider, one quotient bit a cycle
    assign rem_sh  = {rem_reg, num_reg[rcws_pkg::NUM_W-1]};
    assign q_bit   = rem_sh >= {1'b0, dmag_reg};
    assign rem_new = q_bit ? rem_sh - {1'b0, dmag_reg} : rem_sh;

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            num_reg  <= {n_abs[rcws_pkg::MAG_W-1:0], {rcws_pkg::FRAC_SH{1'b0}}};
            dmag_reg <= den_mag;
            rem_reg  <= '0;
            q_reg    <= '0;
            sat_reg  <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[rcws_pkg::NUM_W-2:0], 1'b0};
            rem_reg <= rem_new[rcws_pkg::DEN_W-1:0];
            q_reg   <= {q_reg[rcws_pkg::QUO_W-2:0], q_bit};
            sat_reg <= sat_reg | q_reg[rcws_pkg::QUO_W-1];
        end
    end

    // Bitwise square root, one result bit a cycle
    assign sq_trial = sq_root_reg + sq_bit_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.dist_max)
        begin
            sq_root_reg <= {32'b0, 32'hFFFF_FFFF};
        end
        else if (cmd.sqrt_init)
        begin
            sq_v_reg    <= sum_reg[rcws_pkg::ROOT_W-1:0];
            sq_root_reg <= '0;
            sq_bit_reg  <= rcws_pkg::ROOT_BIT_INIT;
        end
        else if (cmd.sqrt_step)
        begin
            if (sq_v_reg >= sq_trial)
            begin
                sq_v_reg    <= sq_v_reg - sq_trial;
                sq_root_reg <= (sq_root_reg >> 1) + sq_bit_reg;
            end
            else
            begin
                sq_root_reg <= sq_root_reg >> 1;
            end
            sq_bit_reg <= sq_bit_reg >> 2;
        end
    end

    assign distance = best_reg;
    assign no_hit   = !hit_reg;

endmodule

/* hw/rtl/rcws_ctrl.sv */
// Controller: sequences loads, rays, walls and the iterative units.
module rcws_ctrl #(
    parameter int MAX_WALLS = 64,
    parameter int RAY_COUNT = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [6:0]      cfg_wdata,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_cmd,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [2:0]      ray_number,
    output logic            last,
    output rcws_pkg::cmd_t  cmd,
    input  rcws_pkg::stat_t stat
);

    localparam int WC_W = $clog2(MAX_WALLS + 1);

    rcws_pkg::state_t state_reg, state_next;
    logic [6:0]      wall_count_reg;
    logic [WC_W-1:0] wall_reg, wall_next;
    logic [2:0]      ray_reg, ray_next;
    logic [2:0]      step_reg, step_next;
    logic [6:0]      iter_reg, iter_next;

    logic [rcws_pkg::IDX_W-1:0] count_ext;
    logic [rcws_pkg::IDX_W-1:0] n_lim;
    logic                       last_wall;
    logic                       last_ray;

    // Clamp the wall count to the table depth
    assign count_ext = rcws_pkg::IDX_W'(wall_count_reg);
    assign n_lim     = (count_ext > rcws_pkg::IDX_W'(MAX_WALLS))
                     ? rcws_pkg::IDX_W'(MAX_WALLS) : count_ext;
    assign last_wall = (rcws_pkg::IDX_W'(wall_reg) + rcws_pkg::IDX_W'(1)) == n_lim;
    assign last_ray  = ray_reg == 3'(RAY_COUNT - 1);

    assign ray_number = ray_reg;
    assign last       = last_ray;

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rcws_pkg::ST_IDLE;
            wall_count_reg <= '0;
            wall_reg       <= '0;
            ray_reg        <= '0;
            step_reg       <= '0;
            iter_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wall_reg  <= wall_next;
            ray_reg   <= ray_next;
            step_reg  <= step_next;
            iter_reg  <= iter_next;
            if (cfg_we)
            begin
                wall_count_reg <= cfg_wdata;
            end
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next  = state_reg;
        wall_next   = wall_reg;
        ray_next    = ray_reg;
        step_next   = step_reg;
        iter_next   = iter_reg;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        cmd         = '0;
        cmd.ray_idx = ray_reg;
        cmd.rd_addr = rcws_pkg::IDX_W'(wall_reg);

        case (state_reg)
            rcws_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_cmd == rcws_pkg::CMD_LOAD)
                    begin
                        cmd.load_we = 1'b1;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        ray_next       = '0;
                        state_next     = rcws_pkg::ST_RAY;
                    end
                end
            end
            rcws_pkg::ST_RAY:
            begin
                cmd.ray_init = 1'b1;
                wall_next    = '0;
                state_next   = (n_lim == '0) ? rcws_pkg::ST_EMIT : rcws_pkg::ST_READ;
            end
            rcws_pkg::ST_READ:
            begin
                cmd.rd_en  = 1'b1;
                state_next = rcws_pkg::ST_DIFF;
            end
            rcws_pkg::ST_DIFF:
            begin
                cmd.diff_en = 1'b1;
                step_next   = '0;
                state_next  = rcws_pkg::ST_MUL;
            end
            rcws_pkg::ST_MUL:
            begin
                // Six cross products through the one multiplier
                cmd.mul_en = 1'b1;
                step_next  = step_reg + 3'd1;
                case (step_reg)
                    3'd0: cmd.mul_sel = rcws_pkg::MUL_DX_EY;
                    3'd1:
                    begin
                        cmd.mul_sel = rcws_pkg::MUL_DY_EX;
                        cmd.acc_op  = rcws_pkg::ACC_DEN_LOAD;
                    end
                    3'd2:
                    begin
                        cmd.mul_sel = rcws_pkg::MUL_WX_DY;
                        cmd.acc_op  = rcws_pkg::ACC_DEN_SUB;
                    end
                    3'd3:
                    begin
                        cmd.mul_sel = rcws_pkg::MUL_WY_DX;
                        cmd.acc_op  = rcws_pkg::ACC_S_LOAD;
                    end
                    3'd4:
                    begin
                        cmd.mul_sel = rcws_pkg::MUL_WX_EY;
                        cmd.acc_op  = rcws_pkg::ACC_S_SUB;
                    end
                    3'd5:
                    begin
                        cmd.mul_sel = rcws_pkg::MUL_WY_EX;
                        cmd.acc_op  = rcws_pkg::ACC_N_LOAD;
                    end
                    default:
                    begin
                        cmd.mul_en = 1'b0;
                        cmd.acc_op = rcws_pkg::ACC_N_SUB;
                        step_next  = '0;
                        state_next = rcws_pkg::ST_CHECK;
                    end
                endcase
            end
            rcws_pkg::ST_CHECK:
            begin
                if (stat.wall_ok)
                begin
                    cmd.div_init = 1'b1;
                    iter_next    = '0;
                    state_next   = rcws_pkg::ST_DIV;
                end
                else
                begin
                    wall_next  = wall_reg + WC_W'(1);
                    state_next = last_wall ? rcws_pkg::ST_EMIT : rcws_pkg::ST_READ;
                end
            end
            rcws_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                iter_next    = iter_reg + 7'd1;
                if (iter_reg == 7'(rcws_pkg::DIV_STEPS - 1))
                begin
                    state_next = rcws_pkg::ST_RANGE;
                end
            end
            rcws_pkg::ST_RANGE:
            begin
                step_next = '0;
                if (stat.t_sat)
                begin
                    cmd.dist_max = 1'b1;
                    state_next   = rcws_pkg::ST_UPDATE;
                end
                else
                begin
                    state_next = rcws_pkg::ST_SCALE;
                end
            end
            rcws_pkg::ST_SCALE:
            begin
                // Range times direction gives the axis offsets
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0:
                    begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = rcws_pkg::MUL_T_DX;
                    end
                    3'd1:
                    begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = rcws_pkg::MUL_T_DY;
                        cmd.acc_op  = rcws_pkg::ACC_AX_LOAD;
                    end
                    default:
                    begin
                        cmd.acc_op = rcws_pkg::ACC_AY_LOAD;
                        step_next  = '0;
                        state_next = rcws_pkg::ST_SQUARE;
                    end
                endcase
            end
            rcws_pkg::ST_SQUARE:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0:
                    begin
                        if (!stat.ax_fit)
                        begin
                            cmd.dist_max = 1'b1;
                            step_next    = '0;
                            state_next   = rcws_pkg::ST_UPDATE;
                        end
                        else
                        begin
                            cmd.mul_en  = 1'b1;
                            cmd.mul_sel = rcws_pkg::MUL_AX_AX;
                        end
                    end
                    3'd1:
                    begin
                        cmd.mul_en  = 1'b1;
                        cmd.mul_sel = rcws_pkg::MUL_AY_AY;
                        cmd.acc_op  = rcws_pkg::ACC_SUM_LOAD;
                    end
                    default:
                    begin
                        cmd.acc_op = rcws_pkg::ACC_SUM_ADD;
                        step_next  = '0;
                        state_next = rcws_pkg::ST_ROOT_INIT;
                    end
                endcase
            end
            rcws_pkg::ST_ROOT_INIT:
            begin
                iter_next = '0;
                if (stat.sum_ovf)
                begin
                    cmd.dist_max = 1'b1;
                    state_next   = rcws_pkg::ST_UPDATE;
                end
                else
                begin
                    cmd.sqrt_init = 1'b1;
                    state_next    = rcws_pkg::ST_ROOT;
                end
            end
            rcws_pkg::ST_ROOT:
            begin
                cmd.sqrt_step = 1'b1;
                iter_next     = iter_reg + 7'd1;
                if (iter_reg == 7'(rcws_pkg::ROOT_STEPS - 1))
                begin
                    state_next = rcws_pkg::ST_UPDATE;
                end
            end
            rcws_pkg::ST_UPDATE:
            begin
                cmd.upd    = 1'b1;
                wall_next  = wall_reg + WC_W'(1);
                state_next = last_wall ? rcws_pkg::ST_EMIT : rcws_pkg::ST_READ;
            end
            rcws_pkg::ST_EMIT:
            begin
                // Hold the result beat until the receiver takes it
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (last_ray)
                    begin
                        state_next = rcws_pkg::ST_IDLE;
                    end
                    else
                    begin
                        ray_next   = ray_reg + 3'd1;
                        state_next = rcws_pkg::ST_RAY;
                    end
                end
            end
            default:
            begin
                state_next = rcws_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/ray_cast_wall_scanner.sv */
// Top level of the ray cast wall scanner: controller, datapath and checks.
// Use: write the wall count on cfg_we/cfg_wdata while idle. On in_ch, a load
// beat (cmd 0) stores one wall in slot wall_index and returns
// nothing; slots from MAX_WALLS up are dropped. A scan beat (cmd 1) casts
// RAY_COUNT rays from origin_x/origin_y around heading and returns one
// beat per ray on out_ch, in ray order, last set on the final one.
// Per ray, every examined wall goes through the cross products on the one
// shared 34x34 multiplier stage; a rejected wall ends there. An accepted
// wall then runs the restoring divider and, unless its range saturates, the
// scaling and squares on that multiplier and the bitwise square root.
// One item is worked at a time: in_ch.ready is high only while idle.
// A result beat is held in its registers while out_ch.ready is low and the
// block waits. Reset clears the controller and the wall count; the wall
// table is not cleared, and a slot must be loaded before a scan reads it.
module ray_cast_wall_scanner #(
    parameter int MAX_WALLS = 64,
    parameter int RAY_COUNT = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    rcws_in_if.sink    in_ch,
    rcws_out_if.source out_ch
);

    rcws_pkg::cmd_t  cmd;
    rcws_pkg::stat_t stat;

    // Sequencer
    rcws_ctrl #(
        .MAX_WALLS (MAX_WALLS),
        .RAY_COUNT (RAY_COUNT)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_cmd     (in_ch.cmd),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .ray_number (out_ch.ray_number),
        .last       (out_ch.last),
        .cmd        (cmd),
        .stat       (stat)
    );

    // Arithmetic and wall table
    rcws_dpath #(
        .MAX_WALLS (MAX_WALLS)
    ) u_dpath (
        .clk        (clk),
        .cmd        (cmd),
        .stat       (stat),
        .wall_index (in_ch.wall_index),
        .start_x    (in_ch.start_x),
        .start_y    (in_ch.start_y),
        .end_x      (in_ch.end_x),
        .end_y      (in_ch.end_y),
        .origin_x   (in_ch.origin_x),
        .origin_y   (in_ch.origin_y),
        .heading    (in_ch.heading),
        .distance   (out_ch.distance),
        .no_hit     (out_ch.no_hit)
    );

    // Never take a beat while a result is on offer
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input taken while result pending");

    // The final beat carries the last ray number
    a_last_ray: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.last) |-> (out_ch.ray_number == 3'(RAY_COUNT - 1)))
        else $error("last flag on wrong ray");

    // A miss reports a saturated distance
    a_miss_sat: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.no_hit) |-> (&out_ch.distance))
        else $error("miss without saturated distance");

    // A scan beat closes the input until the scan is done
    a_scan_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && (in_ch.cmd == rcws_pkg::CMD_SCAN))
        |=> !in_ch.ready)
        else $error("input reopened right after scan");

endmodule

/* bench/rcws_checker.sv */
// Watches both channels of the wall scanner, predicts every ray beat and compares.
`timescale 1ns / 100ps

module rcws_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    rcws_in_if         in_ch,
    rcws_out_if        out_ch,
    output int         fail_count,
    output int         pending,
    output int         scans_seen,
    output int         hits_seen,
    output int         far_seen
);

    typedef struct {
        logic [31:0] distance;
        logic [2:0]  ray_number;
        logic        no_hit;
        logic        last;
    } ray_beat_t;

    ray_beat_t          range_q[$];
    logic signed [31:0] wall_sx [64];
    logic signed [31:0] wall_sy [64];
    logic signed [31:0] wall_ex [64];
    logic signed [31:0] wall_ey [64];
    logic [6:0]         walls_enabled;

    // Q2.14 direction component for a whole-degree angle
    function automatic longint sine_of(input int a);
        int r;
        r = a % 360;
        if (r <= 90)
            return longint'(rcws_pkg::SIN_Q14[r]);
        else if (r <= 180)
            return longint'(rcws_pkg::SIN_Q14[180 - r]);
        else if (r <= 270)
            return -longint'(rcws_pkg::SIN_Q14[r - 180]);
        return -longint'(rcws_pkg::SIN_Q14[360 - r]);
    endfunction

    // Floor square root, one result bit per step from the top
    function automatic logic [63:0] floor_root(input logic [63:0] v);
        logic [63:0] root;
        logic [63:0] cand;
        root = '0;
        for (int b = 31; b >= 0; b--)
        begin
            cand = root | (64'd1 << b);
            if (cand * cand <= v)
                root = cand;
        end
        return root;
    endfunction

    // Nearest wall along one ray, saturated when nothing is met or too far
    function automatic void nearest_wall(input longint ox, input longint oy, input int theta,
                                         output logic [31:0] best, output logic hit);
        longint             dx, dy, x0, y0, x1, y1, ex, ey, wx, wy, den, s;
        logic signed [95:0] wx_w, wy_w, ex_w, ey_w, n;
        logic [95:0]        nmag, dmag, q;
        logic [63:0]        t, ax, ay, mdx, mdy;
        logic [64:0]        sum;
        logic [31:0]        ray_dist;
        int                 lim;
        dx   = sine_of(theta);
        dy   = sine_of(theta + 90);
        mdx  = dx < 0 ? -dx : dx;
        mdy  = dy < 0 ? -dy : dy;
        best = '1;
        hit  = 1'b0;
        lim  = walls_enabled > 64 ? 64 : walls_enabled;
        for (int k = 0; k < lim; k++)
        begin
            x0  = wall_sx[k];
            y0  = wall_sy[k];
            x1  = wall_ex[k];
            y1  = wall_ey[k];
            ex  = x1 - x0;
            ey  = y1 - y0;
            wx  = x0 - ox;
            wy  = y0 - oy;
            den = dx * ey - dy * ex;
            // drop parallel and zero-length walls
            if (den == 0)
                continue;
            s = wx * dy - wy * dx;
            if (den > 0 ? (s < 0 || s > den) : (s > 0 || s < den))
                continue;
            wx_w = wx;
            wy_w = wy;
            ex_w = ex;
            ey_w = ey;
            n    = wx_w * ey_w - wy_w * ex_w;
            // drop walls behind the sensor
            if (n != 0 && ((n < 0) != (den < 0)))
                continue;
            nmag = n < 0 ? -n : n;
            dmag = den < 0 ? -den : den;
            q    = (nmag << rcws_pkg::FRAC_SH) / dmag;
            t    = (q >= (96'd1 << 33)) ? (64'd1 << 33) : q[63:0];
            ray_dist = '1;
            if (t < (64'd1 << 33))
            begin
                ax = (t * mdx) >> rcws_pkg::FRAC_SH;
                ay = (t * mdy) >> rcws_pkg::FRAC_SH;
                if (ax < (64'd1 << 32) && ay < (64'd1 << 32))
                begin
                    sum = ax * ax + ay * ay;
                    if (!sum[64])
                        ray_dist = floor_root(sum[63:0]);
                end
            end
            hit = 1'b1;
            if (ray_dist < best)
                best = ray_dist;
        end
    endfunction

    // Track the table and the count, queue predictions, compare result beats
    always @(posedge clk or negedge rst_n)
    begin
        ray_beat_t   want;
        logic [31:0] best;
        logic        hit;
        int          theta;
        if (!rst_n)
        begin
            walls_enabled = '0;
            fail_count    = 0;
            scans_seen    = 0;
            hits_seen     = 0;
            far_seen      = 0;
            range_q.delete();
        end
        else
        begin
            if (cfg_we)
                walls_enabled = cfg_wdata;
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.cmd == rcws_pkg::CMD_LOAD)
                begin
                    wall_sx[in_ch.wall_index] = in_ch.start_x;
                    wall_sy[in_ch.wall_index] = in_ch.start_y;
                    wall_ex[in_ch.wall_index] = in_ch.end_x;
                    wall_ey[in_ch.wall_index] = in_ch.end_y;
                end
                else
                begin
                    scans_seen++;
                    for (int r = 0; r < 8; r++)
                    begin
                        theta = (int'(in_ch.heading) % 360 + 360
                                 - int'(rcws_pkg::RAY_OFFSET[r])) % 360;
                        nearest_wall(in_ch.origin_x, in_ch.origin_y, theta, best, hit);
                        want.distance   = best;
                        want.ray_number = r[2:0];
                        want.no_hit     = !hit;
                        want.last       = (r == 7);
                        if (hit)
                            hits_seen++;
                        if (hit && best == '1)
                            far_seen++;
                        range_q = {range_q, want};
                    end
                end
            end
            if (out_ch.valid && out_ch.ready)
            begin
                if (range_q.size() == 0)
                begin
                    $error("unexpected ray beat: distance %h ray %0d",
                           out_ch.distance, out_ch.ray_number);
                    fail_count++;
                end
                else
                begin
                    want = range_q.pop_front();
                    if (out_ch.distance !== want.distance)
                    begin
                        $error("distance: expected %h, got %h", want.distance, out_ch.distance);
                        fail_count++;
                    end
                    if (out_ch.ray_number !== want.ray_number)
                    begin
                        $error("ray_number: expected %0d, got %0d",
                               want.ray_number, out_ch.ray_number);
                        fail_count++;
                    end
                    if (out_ch.no_hit !== want.no_hit)
                    begin
                        $error("no_hit: expected %0d, got %0d", want.no_hit, out_ch.no_hit);
                        fail_count++;
                    end
                    if (out_ch.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, out_ch.last);
                        fail_count++;
                    end
                end
            end
        end
        pending = range_q.size();
    end

endmodule

/* bench/tb_top.sv */
// Stimulus, clock, reset and verdict for the ray cast wall scanner bench.
`timescale 1ns / 100ps

module tb_top;

    localparam int   LIMIT = 25_000_000;
    localparam logic [31:0] UNIT = 32'h0001_0000;

    typedef struct {
        logic               cmd;
        logic [5:0]         slot;
        logic signed [31:0] sx, sy, ex, ey, ox, oy;
        logic [8:0]         hdg;
    } scan_item_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;
    int         fail_count, pending, scans_seen, hits_seen, far_seen;
    int         cycles;
    logic       idle_on;
    logic       hold_req;
    int         hold_cnt;

    rcws_in_if  in_ch ();
    rcws_out_if out_ch ();

    ray_cast_wall_scanner dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    rcws_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending),
        .scans_seen (scans_seen),
        .hits_seen  (hits_seen),
        .far_seen   (far_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Count cycles and stop a hung run
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
        end
    end

    initial
    begin
        wait (cycles >= LIMIT);
        $display("FAILURE");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < 500)
                begin
                    @(posedge clk);
                    hold_cnt++;
                end
                hold_req = 1'b0;
            end
            else
                out_ch.ready <= !(idle_on && $urandom_range(99) < 16);
        end
    end

    // Signed Q16.16 value near the scene centre, now and then any value
    function automatic logic signed [31:0] coord(input int span);
        int v;
        if ($urandom_range(99) < 15)
            return $urandom;
        v = int'($urandom_range(0, 2 * span)) - span;
        return (v * 65536) + int'($urandom_range(0, 65535));
    endfunction

    function automatic scan_item_t mk(input logic cmd, input logic [5:0] slot,
                                      input logic signed [31:0] sx, sy, ex, ey, ox, oy,
                                      input logic [8:0] hdg);
        scan_item_t it;
        it.cmd = cmd;
        it.slot = slot;
        it.sx = sx;
        it.sy = sy;
        it.ex = ex;
        it.ey = ey;
        it.ox = ox;
        it.oy = oy;
        it.hdg = hdg;
        return it;
    endfunction

    function automatic scan_item_t rand_item(input logic cmd, input logic [5:0] slot);
        return mk(cmd, slot, coord(200), coord(200), coord(200), coord(200),
                  coord(50), coord(50), 9'($urandom_range(0, 511)));
    endfunction

    // Offer one beat and hold it until taken
    task automatic push(input scan_item_t it);
        if (idle_on && $urandom_range(99) < 16)
        begin
            in_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < 50);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= it.cmd;
        in_ch.wall_index <= it.slot;
        in_ch.start_x    <= it.sx;
        in_ch.start_y    <= it.sy;
        in_ch.end_x      <= it.ex;
        in_ch.end_y      <= it.ey;
        in_ch.origin_x   <= it.ox;
        in_ch.origin_y   <= it.oy;
        in_ch.heading    <= it.hdg;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Drop valid and wait until every ray beat has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Write the wall count once the block has gone quiet
    task automatic set_walls(input logic [6:0] n);
        drain();
        repeat (40) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int plan [14];
        int n_items;
        logic big;

        plan             = '{3, 0, 2, 64, 5, 1, 4, 127, 2, 6, 3, 1, 4, 2};
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        idle_on          = 1'b1;
        hold_req         = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.cmd        = rcws_pkg::CMD_LOAD;
        in_ch.wall_index = '0;
        in_ch.start_x    = '0;
        in_ch.start_y    = '0;
        in_ch.end_x      = '0;
        in_ch.end_y      = '0;
        in_ch.origin_x   = '0;
        in_ch.origin_y   = '0;
        in_ch.heading    = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, then a small scene of special walls
        set_walls(7'd0);
        push(mk(rcws_pkg::CMD_SCAN, 6'd0, 0, 0, 0, 0, 0, 0, 9'd0));
        // wall ahead at x = 10
        push(mk(rcws_pkg::CMD_LOAD, 6'd0, 10 * UNIT, -10 * UNIT, 10 * UNIT, 10 * UNIT,
                0, 0, 9'd0));
        // zero-length wall
        push(mk(rcws_pkg::CMD_LOAD, 6'd1, 5 * UNIT, 5 * UNIT, 5 * UNIT, 5 * UNIT,
                0, 0, 9'd0));
        // wall behind at x = -10
        push(mk(rcws_pkg::CMD_LOAD, 6'd2, -10 * UNIT, -3 * UNIT, -10 * UNIT, 3 * UNIT,
                0, 0, 9'd0));
        // far wall at the positive x edge, full height
        push(mk(rcws_pkg::CMD_LOAD, 6'd3, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                32'sh7FFF_FFFF, 0, 0, 9'd0));
        // horizontal wall through the origin: parallel to x rays, zero range
        push(mk(rcws_pkg::CMD_LOAD, 6'd4, -5 * UNIT, 0, 5 * UNIT, 0, 0, 0, 9'd0));
        set_walls(7'd5);
        push(mk(rcws_pkg::CMD_SCAN, 6'd0, 0, 0, 0, 0, 0, 0, 9'd93));
        push(mk(rcws_pkg::CMD_SCAN, 6'd0, 0, 0, 0, 0, 0, 0, 9'd0));
        push(mk(rcws_pkg::CMD_SCAN, 6'd0, 0, 0, 0, 0, 0, 0, 9'd359));
        push(mk(rcws_pkg::CMD_SCAN, 6'd0, 0, 0, 0, 0, 0, 0, 9'd360));
        push(mk(rcws_pkg::CMD_SCAN, 6'd0, 0, 0, 0, 0, 0, 0, 9'd511));
        push(mk(rcws_pkg::CMD_SCAN, 6'd0, 0, 0, 0, 0, 0, UNIT, 9'd180));
        push(mk(rcws_pkg::CMD_SCAN, 6'd0, 0, 0, 0, 0, 32'sh8000_0000, 0, 9'd90));
        push(mk(rcws_pkg::CMD_SCAN, 6'd0, 0, 0, 0, 0, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                9'd270));

        // Fill every slot so any wall count reads written entries
        for (int s = 0; s < 64; s++)
            push(rand_item(rcws_pkg::CMD_LOAD, s[5:0]));

        // Random phases over a range of wall counts
        for (int p = 0; p < 14; p++)
        begin
            set_walls(plan[p][6:0]);
            big     = (plan[p] >= 64);
            n_items = big ? 4 : 32;
            idle_on = !(p == 5 || p == 6);
            if (p == 2)
                hold_req = 1'b1;
            for (int k = 0; k < n_items; k++)
            begin
                if (p == 1 && k == 15)
                    drain();
                if (big ? (k % 2 == 1) : ($urandom_range(99) < 40))
                    push(rand_item(rcws_pkg::CMD_SCAN, 6'($urandom_range(0, 63))));
                else
                    push(rand_item(rcws_pkg::CMD_LOAD, 6'($urandom_range(0, 63))));
            end
        end

        drain();
        repeat (60) @(posedge clk);
        $display("Covered %0d scans, %0d ray hits, %0d of them past the distance range.",
                 scans_seen, hits_seen, far_seen);
        $display("Wall counts from 0 to 127, with stalls, a long hold-off and idle stretches.");
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
